[hdl/rfbc_pkg.sv]
package rfbc_pkg;

   // Size of the receive and transmit stores. Must be a power of two, so that
   // slot numbers wrap by truncation.
   localparam int BUFFER_DEPTH = 256;
   localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
   // Indexes and counts reach BUFFER_DEPTH itself.
   localparam int INDEX_W      = $clog2(BUFFER_DEPTH + 1);

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHAR_GAP  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RX_ENABLE = 1'd1;

   // Register values after reset.
   localparam logic [15:0] CHAR_GAP_RESET = 16'd4;

   // Commands carried by an input transaction.
   typedef enum logic [2:0] {
      CMD_RX_BYTE     = 3'd0,
      CMD_TX_LOAD     = 3'd1,
      CMD_TX_START    = 3'd2,
      CMD_TX_COMPLETE = 3'd3,
      CMD_ARM_RECEIVE = 3'd4,
      CMD_TICK        = 3'd5,
      CMD_READ_WORD   = 3'd6
   } cmd_type;

   // Kind of a result transaction.
   typedef enum logic [2:0] {
      KIND_NONE           = 3'd0,
      KIND_LINE_BYTE      = 3'd1,
      KIND_TX_FINISHED    = 3'd2,
      KIND_FRAME_RECEIVED = 3'd3,
      KIND_NO_RESPONSE    = 3'd4,
      KIND_READ_DATA      = 3'd5,
      KIND_READ_INVALID   = 3'd6
   } kind_type;

   // Receive timing phase.
   typedef enum logic [1:0] {
      WAIT_IDLE  = 2'd0,
      WAIT_FIRST = 2'd1,
      WAIT_GAP   = 2'd2
   } wait_phase_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_TX_FETCH,
      ST_RD_HI,
      ST_RD_LO,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic capture;
      logic exec;
      logic take_line;
      logic take_hi;
      logic take_lo;
      logic load_rsp;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic tx_go;
      logic rd_ok;
      logic rsp_free;
   } dp_status_type;

endpackage

[hdl/rfbc_ram.sv]
module rfbc_ram
   #(parameter int WIDTH = 8,
     parameter int DEPTH = 256)
   (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
   );

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hdl/rfbc_ctrl.sv]
module rfbc_ctrl
   import rfbc_pkg::*;
   (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type st,
   output ctl_cmd_type   ctl
   );

   state_type state_ff;
   state_type state_in;

   // State register; reset starts the clearing pass over both stores.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands to the datapath.
   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl.clear = 1'b1;
            if (st.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl.exec = 1'b1;
            if (st.tx_go) begin
               state_in = ST_TX_FETCH;
            end else if (st.rd_ok) begin
               state_in = ST_RD_HI;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_TX_FETCH: begin
            ctl.take_line = 1'b1;
            state_in      = ST_DONE;
         end
         ST_RD_HI: begin
            ctl.take_hi = 1'b1;
            state_in    = ST_RD_LO;
         end
         ST_RD_LO: begin
            ctl.take_lo = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (st.rsp_free) begin
               ctl.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // An accepted transaction is executed in the next cycle.
   a_exec_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> ctl.exec)
      else $error("accepted transaction was not executed");

   // The low byte of a word is taken right after its high byte.
   a_lo_after_hi: assert property (@(posedge clock) disable iff (reset)
      ctl.take_lo |-> $past(ctl.take_hi))
      else $error("low byte taken without high byte");

   // A transmit byte is taken right after the execute cycle that read it.
   a_line_after_exec: assert property (@(posedge clock) disable iff (reset)
      ctl.take_line |-> $past(ctl.exec))
      else $error("line byte taken without a read");

endmodule

[hdl/rfbc_dp.sv]
module rfbc_dp
   import rfbc_pkg::*;
   (
   input  logic                   clock,
   input  logic                   reset,
   // Configuration
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // Input fields
   input  logic [2:0]             req_cmd,
   input  logic [7:0]             req_data_byte,
   input  logic [7:0]             req_position,
   input  logic [8:0]             req_frame_bytes,
   input  logic                   req_parity_error,
   input  logic                   req_overrun_error,
   input  logic                   req_noise_error,
   input  logic [31:0]            req_response_ticks,
   // Result register
   input  logic                   rsp_tready,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_kind,
   output logic [7:0]             rsp_line_byte,
   output logic                   rsp_driver_enable,
   output logic [8:0]             rsp_frame_length,
   output logic [15:0]            rsp_read_word,
   // Controller
   input  ctl_cmd_type            ctl,
   output dp_status_type          st
   );

   // Captured transaction
   cmd_type     cmd_ff,    cmd_in;
   logic [7:0]  data_ff,   data_in;
   logic [7:0]  pos_ff,    pos_in;
   logic [8:0]  nbytes_ff, nbytes_in;
   logic        bad_ff,    bad_in;
   logic [31:0] resp_ff,   resp_in;

   // Configuration
   logic [15:0] gap_ff,    gap_in;
   logic        rx_en_ff,  rx_en_in;

   // Controller state
   logic [INDEX_W-1:0] rx_idx_ff,    rx_idx_in;
   logic [INDEX_W-1:0] frame_len_ff, frame_len_in;
   logic [INDEX_W-1:0] tx_count_ff,  tx_count_in;
   logic [INDEX_W-1:0] tx_idx_ff,    tx_idx_in;
   logic               driver_ff,    driver_in;
   wait_phase_type     phase_ff,     phase_in;
   logic [31:0]        wait_cnt_ff,  wait_cnt_in;
   logic [31:0]        wait_lim_ff,  wait_lim_in;

   // Slot written by the clearing pass after reset.
   logic [ADDR_W-1:0]  clr_addr_ff,  clr_addr_in;

   // Result under construction
   kind_type    kind_ff, kind_in;
   logic [7:0]  line_ff, line_in;
   logic [15:0] word_ff, word_in;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   kind_type    rsp_kind_ff,  rsp_kind_in;
   logic [7:0]  rsp_line_ff,  rsp_line_in;
   logic        rsp_drv_ff,   rsp_drv_in;
   logic [8:0]  rsp_flen_ff,  rsp_flen_in;
   logic [15:0] rsp_word_ff,  rsp_word_in;

   // Store ports
   logic               rx_keep;
   logic               rx_we,    tx_we;
   logic [ADDR_W-1:0]  rx_waddr, tx_waddr;
   logic [7:0]         rx_wdata, tx_wdata;
   logic [ADDR_W-1:0]  rx_raddr, tx_raddr;
   logic [7:0]         rx_rdata, tx_rdata;
   logic [ADDR_W-1:0]  pos_addr;
   logic [INDEX_W-1:0] rx_eff;
   logic [INDEX_W-1:0] tx_sat;
   logic [31:0]        wait_inc;

   rfbc_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_rx_ram (
      .clock (clock),
      .we    (rx_we),
      .waddr (rx_waddr),
      .wdata (rx_wdata),
      .raddr (rx_raddr),
      .rdata (rx_rdata)
   );

   rfbc_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_tx_ram (
      .clock (clock),
      .we    (tx_we),
      .waddr (tx_waddr),
      .wdata (tx_wdata),
      .raddr (tx_raddr),
      .rdata (tx_rdata)
   );

   // Store addressing; the clearing pass writes zeros to both stores.
   always_comb begin
      pos_addr = ADDR_W'(pos_ff);
      rx_eff   = (int'(rx_idx_ff) >= BUFFER_DEPTH) ? '0 : rx_idx_ff;
      rx_keep  = ctl.exec && (cmd_ff == CMD_RX_BYTE) && rx_en_ff && !bad_ff;
      rx_we    = ctl.clear || rx_keep;
      rx_waddr = ctl.clear ? clr_addr_ff : rx_eff[ADDR_W-1:0];
      rx_wdata = ctl.clear ? 8'h00 : data_ff;
      tx_we    = ctl.clear || (ctl.exec && (cmd_ff == CMD_TX_LOAD));
      tx_waddr = ctl.clear ? clr_addr_ff : pos_addr;
      tx_wdata = ctl.clear ? 8'h00 : data_ff;
      rx_raddr = ctl.take_hi ? (pos_addr + ADDR_W'(1)) : pos_addr;
      tx_raddr = (cmd_ff == CMD_TX_START) ? '0 : tx_idx_ff[ADDR_W-1:0];
      tx_sat   = (int'(nbytes_ff) > BUFFER_DEPTH) ? INDEX_W'(BUFFER_DEPTH)
                                                  : INDEX_W'(nbytes_ff);
      wait_inc = (wait_cnt_ff == '1) ? wait_cnt_ff : wait_cnt_ff + 32'd1;
   end

   // Status toward the controller.
   always_comb begin
      st.clear_last = (clr_addr_ff == ADDR_W'(BUFFER_DEPTH - 1));
      st.tx_go    = ((cmd_ff == CMD_TX_START) && (nbytes_ff != 9'd0))
                 || ((cmd_ff == CMD_TX_COMPLETE) && driver_ff && (tx_idx_ff < tx_count_ff));
      st.rd_ok    = (cmd_ff == CMD_READ_WORD) && (int'(pos_ff) < int'(frame_len_ff));
      st.rsp_free = !rsp_valid_ff || rsp_tready;
   end

   // Next values of all registers.
   always_comb begin
      cmd_in       = cmd_ff;
      data_in      = data_ff;
      pos_in       = pos_ff;
      nbytes_in    = nbytes_ff;
      bad_in       = bad_ff;
      resp_in      = resp_ff;
      gap_in       = gap_ff;
      rx_en_in     = rx_en_ff;
      rx_idx_in    = rx_idx_ff;
      frame_len_in = frame_len_ff;
      tx_count_in  = tx_count_ff;
      tx_idx_in    = tx_idx_ff;
      driver_in    = driver_ff;
      phase_in     = phase_ff;
      wait_cnt_in  = wait_cnt_ff;
      wait_lim_in  = wait_lim_ff;
      clr_addr_in  = clr_addr_ff;
      kind_in      = kind_ff;
      line_in      = line_ff;
      word_in      = word_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_line_in  = rsp_line_ff;
      rsp_drv_in   = rsp_drv_ff;
      rsp_flen_in  = rsp_flen_ff;
      rsp_word_in  = rsp_word_ff;

      // Step through the slots during the clearing pass.
      if (ctl.clear) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
      end

      // Register writes.
      if (csr_we) begin
         unique case (csr_index)
            CSR_CHAR_GAP:  gap_in   = csr_wdata[15:0];
            CSR_RX_ENABLE: rx_en_in = csr_wdata[0];
         endcase
      end

      // Take in a new transaction.
      if (ctl.capture) begin
         cmd_in    = cmd_type'(req_cmd);
         data_in   = req_data_byte;
         pos_in    = req_position;
         nbytes_in = req_frame_bytes;
         bad_in    = req_parity_error || req_overrun_error || req_noise_error;
         resp_in   = req_response_ticks;
      end

      // Execute the command against the current state.
      if (ctl.exec) begin
         kind_in = KIND_NONE;
         line_in = 8'h00;
         word_in = 16'h0000;
         case (cmd_ff)
            CMD_RX_BYTE: begin
               if (rx_keep) begin
                  rx_idx_in = rx_eff + INDEX_W'(1);
                  if ((phase_ff == WAIT_FIRST) || (phase_ff == WAIT_GAP)) begin
                     phase_in    = WAIT_GAP;
                     wait_cnt_in = '0;
                  end
               end
            end
            CMD_TX_LOAD: begin
               // The byte goes in through the transmit store's write port.
            end
            CMD_TX_START: begin
               tx_count_in = tx_sat;
               tx_idx_in   = '0;
               if (tx_sat != '0) begin
                  driver_in = 1'b1;
                  tx_idx_in = INDEX_W'(1);
                  kind_in   = KIND_LINE_BYTE;
               end
            end
            CMD_TX_COMPLETE: begin
               if (driver_ff) begin
                  if (tx_idx_ff >= tx_count_ff) begin
                     driver_in = 1'b0;
                     rx_idx_in = '0;
                     kind_in   = KIND_TX_FINISHED;
                  end else begin
                     tx_idx_in = tx_idx_ff + INDEX_W'(1);
                     kind_in   = KIND_LINE_BYTE;
                  end
               end
            end
            CMD_ARM_RECEIVE: begin
               phase_in    = WAIT_FIRST;
               wait_cnt_in = '0;
               wait_lim_in = resp_ff;
            end
            CMD_TICK: begin
               if (phase_ff == WAIT_FIRST) begin
                  wait_cnt_in = wait_inc;
                  if ((wait_lim_ff != '0) && (wait_inc >= wait_lim_ff)) begin
                     phase_in = WAIT_IDLE;
                     kind_in  = KIND_NO_RESPONSE;
                  end
               end else if (phase_ff == WAIT_GAP) begin
                  wait_cnt_in = wait_inc;
                  if (wait_inc >= {16'h0000, gap_ff}) begin
                     frame_len_in = rx_idx_ff;
                     rx_idx_in    = '0;
                     phase_in     = WAIT_IDLE;
                     kind_in      = KIND_FRAME_RECEIVED;
                  end
               end
            end
            CMD_READ_WORD: begin
               kind_in = st.rd_ok ? KIND_READ_DATA : KIND_READ_INVALID;
            end
            default: begin
               kind_in = KIND_NONE;
            end
         endcase
      end

      // Collect bytes read from the stores.
      if (ctl.take_line) begin
         line_in = tx_rdata;
      end
      if (ctl.take_hi) begin
         word_in[15:8] = rx_rdata;
      end
      if (ctl.take_lo) begin
         word_in[7:0] = rx_rdata;
      end

      // Output register: load a finished result, drop a taken one.
      if (ctl.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = kind_ff;
         rsp_line_in  = line_ff;
         rsp_drv_in   = driver_ff;
         rsp_flen_in  = 9'(frame_len_ff);
         rsp_word_in  = word_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff       <= CHAR_GAP_RESET;
         rx_en_ff     <= 1'b1;
         rx_idx_ff    <= '0;
         frame_len_ff <= '0;
         tx_count_ff  <= '0;
         tx_idx_ff    <= '0;
         driver_ff    <= 1'b0;
         phase_ff     <= WAIT_IDLE;
         wait_cnt_ff  <= '0;
         wait_lim_ff  <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gap_ff       <= gap_in;
         rx_en_ff     <= rx_en_in;
         rx_idx_ff    <= rx_idx_in;
         frame_len_ff <= frame_len_in;
         tx_count_ff  <= tx_count_in;
         tx_idx_ff    <= tx_idx_in;
         driver_ff    <= driver_in;
         phase_ff     <= phase_in;
         wait_cnt_ff  <= wait_cnt_in;
         wait_lim_ff  <= wait_lim_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      data_ff      <= data_in;
      pos_ff       <= pos_in;
      nbytes_ff    <= nbytes_in;
      bad_ff       <= bad_in;
      resp_ff      <= resp_in;
      kind_ff      <= kind_in;
      line_ff      <= line_in;
      word_ff      <= word_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_line_ff  <= rsp_line_in;
      rsp_drv_ff   <= rsp_drv_in;
      rsp_flen_ff  <= rsp_flen_in;
      rsp_word_ff  <= rsp_word_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_line_byte     = rsp_line_ff;
   assign rsp_driver_enable = rsp_drv_ff;
   assign rsp_frame_length  = rsp_flen_ff;
   assign rsp_read_word     = rsp_word_ff;

   // The receive write index never passes the store size.
   a_rx_idx_range: assert property (@(posedge clock) disable iff (reset)
      int'(rx_idx_ff) <= BUFFER_DEPTH)
      else $error("receive index beyond store size");

   // The transmit read index never passes the byte count.
   a_tx_idx_range: assert property (@(posedge clock) disable iff (reset)
      tx_idx_ff <= tx_count_ff)
      else $error("transmit index beyond byte count");

   // The driver is switched on only by a transmit start.
   a_driver_on: assert property (@(posedge clock) disable iff (reset)
      $rose(driver_ff) |-> $past(ctl.exec && (cmd_ff == CMD_TX_START)))
      else $error("driver enabled without transmit start");

endmodule

[hdl/rs485_frame_buffer_controller_top.sv]
// Half-duplex RS485 frame controller. Each request transaction carries one
// line event (received byte, transmit load/start/complete, receive arm, tick
// or word read) and produces exactly one response transaction. A transaction
// passes through a capture, an execute and a result step; a transaction that
// sends a transmit byte adds a fetch step, and a valid word read adds a high
// and a low read step. The extra steps come from the registered read port of
// the byte stores, and a word read needs two reads of the receive store's
// single read port. A new request is accepted while the previous response
// waits in the output register, but its result step is held until that
// register is free. After reset a clearing pass writes zero to every slot of
// both stores, and req_tready stays low meanwhile. Registers are to be written
// only while no transaction is in flight; the block itself does not enforce it.
module rs485_frame_buffer_controller_top
   import rfbc_pkg::*;
   (
   input  logic                   clock,
   input  logic                   reset,
   // Configuration
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // Request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [63:0]            req_tdata,  // data_byte, position, frame_bytes, response_ticks
   input  logic [7:0]             req_tuser,  // cmd, parity_error, overrun_error, noise_error
   // Response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [39:0]            rsp_tdata,  // line_byte, driver_enable, frame_length, read_word
   output logic [7:0]             rsp_tuser   // kind
   );

   ctl_cmd_type   ctl;
   dp_status_type st;
   logic [2:0]    rsp_kind;
   logic [7:0]    rsp_line_byte;
   logic          rsp_driver_enable;
   logic [8:0]    rsp_frame_length;
   logic [15:0]   rsp_read_word;

   rfbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .ctl        (ctl)
   );

   rfbc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_cmd            (req_tuser[2:0]),
      .req_data_byte      (req_tdata[7:0]),
      .req_position       (req_tdata[15:8]),
      .req_frame_bytes    (req_tdata[24:16]),
      .req_parity_error   (req_tuser[3]),
      .req_overrun_error  (req_tuser[4]),
      .req_noise_error    (req_tuser[5]),
      .req_response_ticks (req_tdata[56:25]),
      .rsp_tready         (rsp_tready),
      .rsp_valid          (rsp_tvalid),
      .rsp_kind           (rsp_kind),
      .rsp_line_byte      (rsp_line_byte),
      .rsp_driver_enable  (rsp_driver_enable),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_read_word      (rsp_read_word),
      .ctl                (ctl),
      .st                 (st)
   );

   // Pack the response fields, lowest field first.
   assign rsp_tdata = {6'b000000, rsp_read_word, rsp_frame_length,
                       rsp_driver_enable, rsp_line_byte};
   assign rsp_tuser = {5'b00000, rsp_kind};

endmodule

[test/rs485_frame_checker.sv]
`timescale 1ns / 1ps

// Watches the configuration port and both streams of the RS485 frame
// controller. Each accepted request transaction is run through a local copy
// of the controller state, and the response it must produce is queued. Each
// accepted response transaction is compared field by field with the oldest
// queued response.
module rs485_frame_checker
   import rfbc_pkg::*;
   (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [63:0]            req_tdata,  // data_byte, position, frame_bytes, response_ticks
   input  logic [7:0]             req_tuser,  // cmd, parity_error, overrun_error, noise_error
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [39:0]            rsp_tdata,  // line_byte, driver_enable, frame_length, read_word
   input  logic [7:0]             rsp_tuser,  // kind
   output int                     fail_count,
   output int                     outstanding
   );

   // One response transaction, unpacked.
   typedef struct packed {
      kind_type           kind;
      logic [7:0]         line_byte;
      logic               driver_en;
      logic [INDEX_W-1:0] frame_len;
      logic [15:0]        word;
   } line_rsp_type;

   // Local copy of the controller state and its registers.
   logic [7:0]         rx_mem [BUFFER_DEPTH];
   logic [7:0]         tx_mem [BUFFER_DEPTH];
   logic [INDEX_W-1:0] rx_wr_idx;
   logic [INDEX_W-1:0] frame_len;
   logic [INDEX_W-1:0] tx_total;
   logic [INDEX_W-1:0] tx_rd_idx;
   logic               drv_on;
   wait_phase_type     phase;
   logic [31:0]        wait_cnt;
   logic [31:0]        wait_lim;
   logic [15:0]        gap_ticks;
   logic               rx_en;

   // Responses that are owed, oldest first.
   line_rsp_type expected_rsp [$];
   int           rsp_seen;

   initial begin
      fail_count  = 0;
      outstanding = 0;
      rsp_seen    = 0;
   end

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("%0t: response %0d, %s: expected 0x%0h, got 0x%0h",
               $time, rsp_seen, what, want, got);
      fail_count++;
   endtask

   // Returns the state to its values after reset.
   task automatic clear_line_state();
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
         rx_mem[i] = '0;
         tx_mem[i] = '0;
      end
      rx_wr_idx = '0;
      frame_len = '0;
      tx_total  = '0;
      tx_rd_idx = '0;
      drv_on    = 1'b0;
      phase     = WAIT_IDLE;
      wait_cnt  = '0;
      wait_lim  = '0;
      gap_ticks = CHAR_GAP_RESET;
      rx_en     = 1'b1;
   endtask

   // Applies one line event to the state and works out its response.
   task automatic advance_line_state(input cmd_type op, input logic [7:0] byte_v,
                                     input logic [ADDR_W-1:0] pos_v,
                                     input logic [8:0] count_v, input logic bad,
                                     input logic [31:0] resp, output line_rsp_type r);
      logic [ADDR_W-1:0] next_pos;
      r        = '0;
      r.kind   = KIND_NONE;
      next_pos = pos_v + 1'b1;
      case (op)
         CMD_RX_BYTE: begin
            // Clean bytes are stored whatever the phase; only an armed
            // receive restarts the gap timing.
            if (rx_en && !bad) begin
               if (rx_wr_idx >= BUFFER_DEPTH) rx_wr_idx = '0;
               rx_mem[rx_wr_idx[ADDR_W-1:0]] = byte_v;
               rx_wr_idx++;
               if (phase != WAIT_IDLE) begin
                  phase    = WAIT_GAP;
                  wait_cnt = '0;
               end
            end
         end
         CMD_TX_LOAD: begin
            tx_mem[pos_v] = byte_v;
         end
         CMD_TX_START: begin
            tx_total  = (count_v > BUFFER_DEPTH) ? INDEX_W'(BUFFER_DEPTH) : count_v;
            tx_rd_idx = '0;
            if (tx_total != 0) begin
               drv_on      = 1'b1;
               r.line_byte = tx_mem[0];
               tx_rd_idx   = INDEX_W'(1);
               r.kind      = KIND_LINE_BYTE;
            end
         end
         CMD_TX_COMPLETE: begin
            // A completion with the driver off is stray and ignored.
            if (drv_on) begin
               if (tx_rd_idx >= tx_total) begin
                  drv_on    = 1'b0;
                  rx_wr_idx = '0;
                  r.kind    = KIND_TX_FINISHED;
               end else begin
                  r.line_byte = tx_mem[tx_rd_idx[ADDR_W-1:0]];
                  tx_rd_idx++;
                  r.kind = KIND_LINE_BYTE;
               end
            end
         end
         CMD_ARM_RECEIVE: begin
            phase    = WAIT_FIRST;
            wait_cnt = '0;
            wait_lim = resp;
         end
         CMD_TICK: begin
            // A zero response timeout never expires.
            if (phase == WAIT_FIRST) begin
               if (wait_cnt != '1) wait_cnt++;
               if (wait_lim != 0 && wait_cnt >= wait_lim) begin
                  phase  = WAIT_IDLE;
                  r.kind = KIND_NO_RESPONSE;
               end
            end else if (phase == WAIT_GAP) begin
               if (wait_cnt != '1) wait_cnt++;
               if (wait_cnt >= {16'd0, gap_ticks}) begin
                  frame_len = rx_wr_idx;
                  rx_wr_idx = '0;
                  phase     = WAIT_IDLE;
                  r.kind    = KIND_FRAME_RECEIVED;
               end
            end
         end
         CMD_READ_WORD: begin
            // The word at the last slot takes its low byte from slot 0.
            if (pos_v < frame_len) begin
               r.word = {rx_mem[pos_v], rx_mem[next_pos]};
               r.kind = KIND_READ_DATA;
            end else begin
               r.kind = KIND_READ_INVALID;
            end
         end
         default: ;
      endcase
      r.driver_en = drv_on;
      r.frame_len = frame_len;
   endtask

   // Compares one accepted response with the oldest owed response.
   task automatic check_response();
      line_rsp_type want;
      line_rsp_type got;
      got.kind      = kind_type'(rsp_tuser[2:0]);
      got.line_byte = rsp_tdata[7:0];
      got.driver_en = rsp_tdata[8];
      got.frame_len = rsp_tdata[17:9];
      got.word      = rsp_tdata[33:18];
      if (expected_rsp.size() == 0) begin
         report_mismatch("transaction with nothing owed, kind", 32'd0, 32'(got.kind));
      end else begin
         want = expected_rsp.pop_front();
         if (got.kind !== want.kind)
            report_mismatch("kind", 32'(want.kind), 32'(got.kind));
         if (got.line_byte !== want.line_byte)
            report_mismatch("line_byte", 32'(want.line_byte), 32'(got.line_byte));
         if (got.driver_en !== want.driver_en)
            report_mismatch("driver_enable", 32'(want.driver_en), 32'(got.driver_en));
         if (got.frame_len !== want.frame_len)
            report_mismatch("frame_length", 32'(want.frame_len), 32'(got.frame_len));
         if (got.word !== want.word)
            report_mismatch("read_word", 32'(want.word), 32'(got.word));
      end
      rsp_seen++;
   endtask

   // Samples the ports at each rising edge: register writes, then responses,
   // then new requests.
   always @(posedge clock) begin
      line_rsp_type owed;
      if (reset) begin
         clear_line_state();
         expected_rsp.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CHAR_GAP:  gap_ticks = csr_wdata[15:0];
               CSR_RX_ENABLE: rx_en     = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) check_response();
         if (req_tvalid && req_tready) begin
            advance_line_state(cmd_type'(req_tuser[2:0]), req_tdata[7:0], req_tdata[15:8],
                               req_tdata[24:16], |req_tuser[5:3], req_tdata[56:25], owed);
            expected_rsp.push_back(owed);
         end
      end
      outstanding <= expected_rsp.size();
   end

endmodule

[test/tb_rs485_frame_buffer_controller_top.sv]
`timescale 1ns / 1ps

// Drives line events into the RS485 frame controller through its request
// stream and throttles its response stream, while a checker beside the block
// predicts and compares every response.
module tb_rs485_frame_buffer_controller_top;
   import rfbc_pkg::*;

   // Ways the response side takes transactions.
   typedef enum int {
      RDY_ALWAYS,
      RDY_MOSTLY,
      RDY_TOGGLE,
      RDY_SPARSE
   } ready_mode_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [63:0]            req_tdata  = '0;  // data_byte, position, frame_bytes, response_ticks
   logic [7:0]             req_tuser  = '0;  // cmd, parity_error, overrun_error, noise_error
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [39:0]            rsp_tdata;        // line_byte, driver_enable, frame_length, read_word
   logic [7:0]             rsp_tuser;        // kind

   int             fail_count;
   int             outstanding;
   int             items_sent = 0;
   int             burst_left = 0;
   logic [15:0]    cur_gap    = CHAR_GAP_RESET;
   ready_mode_type ready_mode = RDY_ALWAYS;
   int             ready_span = 0;

   rs485_frame_buffer_controller_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   rs485_frame_checker frame_check (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The response side switches between ready patterns, each held for a random span.
   always @(posedge clock) begin
      if (ready_span == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         ready_span = $urandom_range(16, 160);
      end
      ready_span--;
      case (ready_mode)
         RDY_ALWAYS: rsp_tready <= 1'b1;
         RDY_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
         RDY_TOGGLE: rsp_tready <= ~rsp_tready;
         default:    rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Sends one request transaction. Transactions go out in bursts with
   // random gaps between them.
   task automatic line_event(input cmd_type op, input logic [7:0] byte_v,
                             input logic [7:0] pos_v, input logic [8:0] count_v,
                             input logic [2:0] errs, input logic [31:0] resp);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 32);
      end
      req_tdata  <= {7'd0, resp, count_v, pos_v, byte_v};
      req_tuser  <= {2'd0, errs, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      items_sent++;
   endtask

   // The error bits are parity, overrun and noise, lowest first.
   task automatic rx_byte_event(input logic [7:0] b, input logic [2:0] errs);
      line_event(CMD_RX_BYTE, b, 8'd0, 9'd0, errs, 32'd0);
   endtask

   task automatic tx_load_event(input logic [7:0] slot, input logic [7:0] b);
      line_event(CMD_TX_LOAD, b, slot, 9'd0, 3'd0, 32'd0);
   endtask

   task automatic tx_start_event(input logic [8:0] n);
      line_event(CMD_TX_START, 8'd0, 8'd0, n, 3'd0, 32'd0);
   endtask

   task automatic tx_complete_events(input int n);
      repeat (n) line_event(CMD_TX_COMPLETE, 8'd0, 8'd0, 9'd0, 3'd0, 32'd0);
   endtask

   task automatic arm_event(input logic [31:0] timeout);
      line_event(CMD_ARM_RECEIVE, 8'd0, 8'd0, 9'd0, 3'd0, timeout);
   endtask

   task automatic tick_events(input int n);
      repeat (n) line_event(CMD_TICK, 8'd0, 8'd0, 9'd0, 3'd0, 32'd0);
   endtask

   task automatic read_event(input logic [7:0] p);
      line_event(CMD_READ_WORD, 8'd0, p, 9'd0, 3'd0, 32'd0);
   endtask

   // Stops sending and waits until every owed response has come, then lets the
   // block settle.
   task automatic quiesce();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
   endtask

   // Writes one register; only called while no transaction is in flight. The
   // enable drops before the next write.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_CHAR_GAP) cur_gap = val;
      @(posedge clock);
   endtask

   // An armed (usually) receive of a short frame with occasional bad bytes,
   // then the gap ticks and a few word reads.
   task automatic rx_frame_run();
      int n;
      int eff;
      logic [31:0] timeout;
      if ($urandom_range(0, 4) != 0) begin
         case ($urandom_range(0, 5))
            0:       timeout = 32'd0;
            1:       timeout = $urandom_range(1, 4);
            2:       timeout = $urandom;
            3:       timeout = 32'hFFFF_FFFF;
            default: timeout = $urandom_range(5, 30);
         endcase
         arm_event(timeout);
         if ($urandom_range(0, 3) == 0) tick_events($urandom_range(1, 4));
      end
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         rx_byte_event(8'($urandom),
                       ($urandom_range(0, 5) == 0) ? 3'($urandom_range(1, 7)) : 3'd0);
         // Idle ticks inside the frame stay short of the gap.
         if (cur_gap >= 3 && $urandom_range(0, 3) == 0)
            tick_events($urandom_range(1, (cur_gap - 2 > 6) ? 6 : cur_gap - 2));
      end
      eff = (cur_gap == 0) ? 1 : cur_gap;
      if (eff > 20) eff = 20;
      tick_events(($urandom_range(0, 4) == 0) ? eff - 1 : eff + $urandom_range(0, 2));
      repeat ($urandom_range(1, 4))
         read_event(($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, n + 1)));
   endtask

   // Loads a few slots and sends a short frame, sometimes cut short, with the
   // odd received byte in between.
   task automatic tx_run();
      int n;
      int k;
      repeat ($urandom_range(1, 6))
         tx_load_event(($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)),
                       8'($urandom));
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 256) : $urandom_range(0, 10);
      k = (n > 16 || $urandom_range(0, 4) == 0) ? $urandom_range(0, 4)
                                                : n + 1 + $urandom_range(0, 1);
      tx_start_event(9'(n));
      for (int i = 0; i < k; i++) begin
         if ($urandom_range(0, 5) == 0) rx_byte_event(8'($urandom), 3'd0);
         tx_complete_events(1);
      end
   endtask

   // Events of any kind with every field random.
   task automatic noise_run();
      repeat ($urandom_range(1, 6))
         line_event(cmd_type'(3'($urandom_range(0, 6))), 8'($urandom), 8'($urandom),
                    9'($urandom_range(0, 256)), 3'($urandom), $urandom);
   endtask

   // Receives a frame of n clean bytes and reads across its end.
   task automatic long_frame(input int n);
      arm_event(32'd0);
      repeat (n) rx_byte_event(8'($urandom), 3'd0);
      tick_events(((cur_gap == 0) ? 1 : cur_gap) + 1);
      read_event(8'd255);
      read_event(8'd254);
      read_event(8'd0);
      read_event(8'($urandom));
   endtask

   // Main stimulus.
   initial begin
      int          target;
      logic [15:0] gap_val;
      logic        en_val;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      csr_write(CSR_CHAR_GAP, 16'd4);
      csr_write(CSR_RX_ENABLE, 16'd1);

      // Directed part: transmit corners first.
      tx_load_event(8'd0, 8'hA5);
      tx_load_event(8'd255, 8'hFF);
      tx_load_event(8'd1, 8'h5A);
      tx_start_event(9'd0);           // empty start sends nothing
      tx_complete_events(1);          // stray completion, driver off
      tx_start_event(9'd2);
      tx_start_event(9'd256);         // restart while sending
      tx_complete_events(1);
      tx_start_event(9'd1);
      tx_complete_events(1);          // finishes and clears the receive index

      // Response timeout, then a byte while not armed.
      arm_event(32'd2);
      tick_events(2);
      rx_byte_event(8'h3C, 3'd0);

      // Armed with no timeout; each error flag drops its byte.
      arm_event(32'd0);
      tick_events(1);
      rx_byte_event(8'hFF, 3'b001);
      rx_byte_event(8'h12, 3'd0);
      rx_byte_event(8'h00, 3'b010);
      rx_byte_event(8'h77, 3'b100);
      rx_byte_event(8'h34, 3'd0);
      tick_events(4);
      read_event(8'd0);
      read_event(8'd2);
      read_event(8'd3);
      read_event(8'd255);
      arm_event(32'hFFFF_FFFF);

      // Random part in phases, each with its own register settings.
      for (int ph = 0; ph < 6; ph++) begin
         en_val = 1'b1;
         case (ph)
            0:       gap_val = 16'd1;
            1:       gap_val = 16'd0;
            2: begin
               gap_val = 16'd3;
               en_val  = 1'b0;
            end
            3:       gap_val = 16'hFFFF;
            4:       gap_val = 16'($urandom_range(2, 6));
            default: gap_val = 16'd2;
         endcase
         quiesce();
         csr_write(CSR_CHAR_GAP, gap_val);
         csr_write(CSR_RX_ENABLE, {15'd0, en_val});

         // One long transmission and two long frames, one of them wrapping.
         if (ph == 1) begin
            repeat (16) tx_load_event(8'($urandom), 8'($urandom));
            tx_start_event(9'd256);
            tx_complete_events(258);
         end
         if (ph == 4) long_frame(256);
         if (ph == 5) long_frame(300);

         target = items_sent + 150;
         while (items_sent < target) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: rx_frame_run();
               5, 6, 7:       tx_run();
               default:       noise_run();
            endcase
         end
      end

      quiesce();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_rs485_frame_buffer_controller_top: done, clean");
      end else begin
         $display("tb_rs485_frame_buffer_controller_top: done, errors");
      end
      $finish;
   end

   // Hard limit on the run.
   initial begin
      #3_000_000;
      $display("tb_rs485_frame_buffer_controller_top: done, errors");
      $finish;
   end

endmodule
